FILE: rtl/core/nmea_gga_pkg.sv
package nmea_gga_pkg;

	// longest line before it is flagged malformed
	localparam int MAX_LINE_LENGTH = 82;
	// decimal fraction digits kept in field values
	localparam int FRAC_DIGITS = 4;

	localparam int MAG_W = 39;
	localparam int VAL_W = 40;
	localparam int SUM_W = 44;
	localparam int WT_W  = 24;
	localparam int OUT_W = 72;

	localparam logic [SUM_W-1:0] MAG_LIMIT = 44'h07F_FFFF_FFFF;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_S      = 8'h53;
	localparam logic [7:0] CH_W      = 8'h57;

	localparam logic [3:0] FLD_TIME        = 4'd0;
	localparam logic [3:0] FLD_LAT         = 4'd1;
	localparam logic [3:0] FLD_LAT_HEMI    = 4'd2;
	localparam logic [3:0] FLD_LON         = 4'd3;
	localparam logic [3:0] FLD_LON_HEMI    = 4'd4;
	localparam logic [3:0] FLD_FIX         = 4'd5;
	localparam logic [3:0] FLD_SATS        = 4'd6;
	localparam logic [3:0] FLD_ALT_UNITS   = 4'd9;
	localparam logic [3:0] FLD_GEOID_UNITS = 4'd11;
	localparam logic [3:0] FLD_AGE         = 4'd12;
	localparam logic [3:0] FLD_STATION     = 4'd13;

	localparam logic KIND_FIELD   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_BAD_PREFIX   = 3'd1,
		ST_UNKNOWN_TYPE = 3'd2,
		ST_MALFORMED    = 3'd3,
		ST_UNSUPPORTED  = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		SENT_UNKNOWN = 3'd0,
		SENT_GGA     = 3'd1,
		SENT_GLL     = 3'd2,
		SENT_GSA     = 3'd3,
		SENT_GSV     = 3'd4,
		SENT_RMC     = 3'd5
	} sent_type_t;

	function automatic logic [7:0] lead_char(input logic [1:0] p);
		case (p)
			2'd0: lead_char = CH_DOLLAR;
			2'd1: lead_char = CH_G;
			2'd2: lead_char = CH_P;
			default: lead_char = 8'h00;
		endcase
	endfunction

	// letter j of known sentence type i
	function automatic logic [7:0] type_char(input logic [2:0] i, input logic [1:0] j);
		logic [23:0] word;
		case (i)
			3'd0: word = "GGA";
			3'd1: word = "GLL";
			3'd2: word = "GSA";
			3'd3: word = "GSV";
			3'd4: word = "RMC";
			default: word = 24'h0;
		endcase
		case (j)
			2'd0: type_char = word[23:16];
			2'd1: type_char = word[15:8];
			2'd2: type_char = word[7:0];
			default: type_char = 8'h00;
		endcase
	endfunction

	function automatic logic [WT_W-1:0] pow10(input logic [2:0] k);
		case (k)
			3'd0: pow10 = 24'd1;
			3'd1: pow10 = 24'd10;
			3'd2: pow10 = 24'd100;
			3'd3: pow10 = 24'd1000;
			3'd4: pow10 = 24'd10000;
			3'd5: pow10 = 24'd100000;
			3'd6: pow10 = 24'd1000000;
			default: pow10 = 24'd0;
		endcase
	endfunction

	// digit times a power of ten, at most 9e6
	function automatic logic [WT_W-1:0] digit_weight(input logic [3:0] d,
			input logic [2:0] k);
		digit_weight = WT_W'(d) * pow10(k);
	endfunction

	// bit 4 set when c is a hex digit
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) begin
			hex_digit = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			hex_digit = {1'b1, c[3:0] + 4'd9};
		end else begin
			hex_digit = 5'd0;
		end
	endfunction

	function automatic logic whole_field(input logic [3:0] f);
		whole_field = (f == FLD_TIME) || (f == FLD_FIX) || (f == FLD_SATS) ||
			(f == FLD_AGE) || (f == FLD_STATION);
	endfunction

endpackage

FILE: rtl/core/nmea_gga_sentence_parser.sv
// each result passes the input register, then the result register
// throughput: one character per cycle, no stall while the result side keeps up
// a character that closes no field gives no result; line end always gives a summary
// reset: arst_n clears parser state and both handshake stages at once, no clearing pass
// parser state returns to its reset value after every line end
module nmea_gga_sentence_parser
	import nmea_gga_pkg::*;
#(
	parameter int LINE_LIMIT = MAX_LINE_LENGTH,
	parameter int FRAC_KEEP  = FRAC_DIGITS
)
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_axis_tvalid,
	output logic             s_axis_tready,
	input  logic [7:0]       s_axis_tdata,  // [7:0] char_code
	input  logic             s_axis_tlast,  // line_end
	output logic             m_axis_tvalid,
	input  logic             m_axis_tready,
	// [3:0] field_index, [43:4] field_value, [46:44] status, [49:47] sentence_type,
	// [57:50] received_checksum, [65:58] calc_checksum, [66] checksum_match
	output logic [OUT_W-1:0] m_axis_tdata,
	output logic             m_axis_tuser   // kind
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// result register
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             out_kind_q;

	// parser state
	logic [6:0]       pos_q;
	logic [4:0]       tmf_q;
	sent_type_t       type_q;
	logic [3:0]       field_q;
	logic [MAG_W-1:0] mag_q;
	logic             neg_q;
	logic             nonempty_q;
	logic             stop_q;
	logic [2:0]       code_q;
	logic [VAL_W-1:0] held_q;
	logic [7:0]       first_q;
	logic [7:0]       xor_q;
	logic [7:0]       hex_q;
	logic             star_q;
	logic             hex_done_q;
	status_t          err_q;

	logic       adv;
	logic       commit;

	logic [6:0]       n_pos;
	logic [4:0]       n_tmf;
	sent_type_t       n_type;
	logic [3:0]       n_field;
	logic [MAG_W-1:0] n_mag;
	logic             n_neg;
	logic             n_nonempty;
	logic             n_stop;
	logic [2:0]       n_code;
	logic [VAL_W-1:0] n_held;
	logic [7:0]       n_first;
	logic [7:0]       n_xor;
	logic [7:0]       n_hex;
	logic             n_star;
	logic             n_hex_done;
	status_t          n_err;

	logic             due;
	logic [3:0]       res_idx;
	logic [VAL_W-1:0] res_val;
	status_t          sum_status;
	logic [7:0]       sum_made;

	assign adv           = !out_valid_q || m_axis_tready;
	assign commit        = adv && valid_s1;
	assign s_axis_tready = !valid_s1 || adv;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_kind_q;

	always_comb begin
		logic [7:0]       c;
		logic [1:0]       tsel;
		logic [2:0]       pick;
		logic [4:0]       hx;
		logic             is_digit;
		logic             skip;
		logic [2:0]       wexp;
		logic [SUM_W-1:0] base;
		logic [SUM_W-1:0] sum;
		logic [MAG_W-1:0] sat;
		logic [VAL_W-1:0] val_s;
		logic [7:0]       hemi;

		c          = char_s1;
		n_pos      = pos_q;
		n_tmf      = tmf_q;
		n_type     = type_q;
		n_field    = field_q;
		n_mag      = mag_q;
		n_neg      = neg_q;
		n_nonempty = nonempty_q;
		n_stop     = stop_q;
		n_code     = code_q;
		n_held     = held_q;
		n_first    = first_q;
		n_xor      = xor_q;
		n_hex      = hex_q;
		n_star     = star_q;
		n_hex_done = hex_done_q;
		n_err      = err_q;
		due        = 1'b0;
		res_idx    = 4'd0;
		res_val    = '0;
		pick       = 3'd0;
		tsel       = 2'(pos_q - 7'd3);

		// line length limit, prefix and type letters
		if (pos_q >= 7'(LINE_LIMIT) && n_err == ST_OK) begin
			n_err = ST_MALFORMED;
		end
		if (pos_q < 7'd3 && c != lead_char(pos_q[1:0]) && n_err == ST_OK) begin
			n_err = ST_BAD_PREFIX;
		end
		if (pos_q >= 7'd3 && pos_q <= 7'd5) begin
			for (int i = 0; i < 5; i++) begin
				if (type_char(3'(i), tsel) != c) begin
					n_tmf[i] = 1'b0;
				end
			end
			for (int i = 4; i >= 0; i--) begin
				if (n_tmf[i]) begin
					pick = 3'(i);
				end
			end
			if (pos_q == 7'd5 && n_err == ST_OK) begin
				if (n_tmf == 5'd0) begin
					n_err = ST_UNKNOWN_TYPE;
				end else begin
					n_type = sent_type_t'(pick + 3'd1);
					if (n_type != SENT_GGA) begin
						n_err = ST_UNSUPPORTED;
					end
				end
			end
		end

		// checksum
		hx = hex_digit(c);
		if (!star_q) begin
			if (c == CH_STAR) begin
				n_star = 1'b1;
			end else if (pos_q != 7'd0) begin
				n_xor = xor_q ^ c;
			end
		end else if (!hex_done_q) begin
			if (hx[4]) begin
				n_hex = {hex_q[3:0], hx[3:0]};
			end else begin
				n_hex_done = 1'b1;
			end
		end

		// number datapath: integer digits scale by ten, fraction digits add a smaller weight
		is_digit = c >= CH_ZERO && c <= CH_NINE;
		wexp     = (code_q == 3'd0) ? 3'(FRAC_KEEP) : 3'(3'(FRAC_KEEP) - code_q);
		base     = (code_q == 3'd0) ? ({5'd0, mag_q} << 3) + ({5'd0, mag_q} << 1)
			: {5'd0, mag_q};
		sum      = base + SUM_W'(digit_weight(c[3:0], wexp));
		sat      = (sum > MAG_LIMIT) ? MAG_LIMIT[MAG_W-1:0] : sum[MAG_W-1:0];
		val_s    = neg_q ? (~{1'b0, mag_q} + 40'd1) : {1'b0, mag_q};
		hemi     = (field_q == FLD_LAT_HEMI) ? CH_S : CH_W;
		skip     = !nonempty_q && (c == CH_MINUS || c == CH_PLUS);

		if (n_type == SENT_GGA && n_err == ST_OK) begin
			if (pos_q == 7'd6) begin
				if (n_star) begin
					n_err = ST_MALFORMED;
				end
			end else if (pos_q >= 7'd7) begin
				if (star_q) begin
					if (c == CH_COMMA) begin
						n_err = ST_MALFORMED;
					end
				end else if (c == CH_COMMA && field_q >= FLD_STATION) begin
					n_err = ST_MALFORMED;
				end else if (c == CH_STAR && field_q != FLD_STATION) begin
					n_err = ST_MALFORMED;
				end else if (c == CH_COMMA || c == CH_STAR) begin
					// field closes
					case (field_q)
						FLD_LAT, FLD_LON: begin
							n_held = val_s;
						end
						FLD_LAT_HEMI, FLD_LON_HEMI: begin
							due     = 1'b1;
							res_idx = field_q - 4'd1;
							res_val = (first_q == hemi) ? (~held_q + 40'd1) : held_q;
						end
						FLD_ALT_UNITS, FLD_GEOID_UNITS: begin
							due     = 1'b1;
							res_idx = field_q;
							res_val = {32'd0, first_q};
						end
						default: begin
							due     = 1'b1;
							res_idx = field_q;
							res_val = val_s;
						end
					endcase
					if (c == CH_COMMA) begin
						n_field    = field_q + 4'd1;
						n_mag      = '0;
						n_neg      = 1'b0;
						n_nonempty = 1'b0;
						n_stop     = 1'b0;
						n_code     = 3'd0;
						n_first    = 8'd0;
					end
				end else begin
					if (!nonempty_q) begin
						n_nonempty = 1'b1;
						n_first    = c;
						if (c == CH_MINUS) begin
							n_neg = 1'b1;
						end
					end
					if (!skip && !stop_q) begin
						if (is_digit) begin
							if (code_q == 3'd0) begin
								n_mag = sat;
							end else if (code_q <= 3'(FRAC_KEEP)) begin
								n_mag  = sat;
								n_code = code_q + 3'd1;
							end
						end else if (c == CH_DOT && code_q == 3'd0 && !whole_field(field_q)) begin
							n_code = 3'd1;
						end else begin
							n_stop = 1'b1;
						end
					end
				end
			end
		end

		if (pos_q != 7'd127) begin
			n_pos = pos_q + 7'd1;
		end

		// summary checks for short lines and a missing star
		sum_status = n_err;
		if (n_err == ST_OK) begin
			if (n_pos < 7'd3) begin
				sum_status = ST_BAD_PREFIX;
			end else if (n_pos < 7'd6) begin
				sum_status = ST_UNKNOWN_TYPE;
			end else if (n_type == SENT_GGA && !n_star) begin
				sum_status = ST_MALFORMED;
			end
		end
		sum_made = n_star ? n_xor : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			pos_q       <= 7'd0;
			tmf_q       <= 5'h1F;
			type_q      <= SENT_UNKNOWN;
			field_q     <= 4'd0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			nonempty_q  <= 1'b0;
			stop_q      <= 1'b0;
			code_q      <= 3'd0;
			held_q      <= '0;
			first_q     <= 8'd0;
			xor_q       <= 8'd0;
			hex_q       <= 8'd0;
			star_q      <= 1'b0;
			hex_done_q  <= 1'b0;
			err_q       <= ST_OK;
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv) begin
				out_valid_q <= valid_s1 && (last_s1 || due);
			end
			if (commit && last_s1) begin
				pos_q      <= 7'd0;
				tmf_q      <= 5'h1F;
				type_q     <= SENT_UNKNOWN;
				field_q    <= 4'd0;
				mag_q      <= '0;
				neg_q      <= 1'b0;
				nonempty_q <= 1'b0;
				stop_q     <= 1'b0;
				code_q     <= 3'd0;
				held_q     <= '0;
				first_q    <= 8'd0;
				xor_q      <= 8'd0;
				hex_q      <= 8'd0;
				star_q     <= 1'b0;
				hex_done_q <= 1'b0;
				err_q      <= ST_OK;
			end else if (commit) begin
				pos_q      <= n_pos;
				tmf_q      <= n_tmf;
				type_q     <= n_type;
				field_q    <= n_field;
				mag_q      <= n_mag;
				neg_q      <= n_neg;
				nonempty_q <= n_nonempty;
				stop_q     <= n_stop;
				code_q     <= n_code;
				held_q     <= n_held;
				first_q    <= n_first;
				xor_q      <= n_xor;
				hex_q      <= n_hex;
				star_q     <= n_star;
				hex_done_q <= n_hex_done;
				err_q      <= n_err;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
		if (commit) begin
			if (last_s1) begin
				out_kind_q <= KIND_SUMMARY;
				out_data_q <= {5'd0, n_hex == sum_made, sum_made, n_hex, n_type,
					sum_status, 40'd0, 4'd0};
			end else begin
				out_kind_q <= KIND_FIELD;
				out_data_q <= {5'd0, 1'b0, 8'd0, 8'd0, SENT_GGA, ST_OK, res_val, res_idx};
			end
		end
	end

	// field results only come from a clean GGA line
	a_field_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_FIELD |->
			out_data_q[46:44] == ST_OK && out_data_q[49:47] == SENT_GGA)
		else $error("field result outside a clean GGA line");

	a_field_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_FIELD |->
			out_data_q[3:0] != FLD_LAT_HEMI && out_data_q[3:0] != FLD_LON_HEMI &&
			out_data_q[3:0] <= FLD_STATION)
		else $error("field result with a held or out of range index");

	a_match_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_SUMMARY |->
			out_data_q[66] == (out_data_q[57:50] == out_data_q[65:58]))
		else $error("checksum match flag disagrees with checksums");

	a_line_reset: assert property (@(posedge clk) disable iff (!arst_n)
		commit && last_s1 |=> pos_q == 7'd0 && field_q == 4'd0 && !star_q &&
			err_q == ST_OK)
		else $error("parser state not cleared after line end");

endmodule

FILE: tb/tb.sv
module tb;
	import nmea_gga_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [39:0] MAG_MAX = 40'h7F_FFFF_FFFF;
	// known sentence names, first name in the lowest bits
	localparam logic [119:0] TYPE_NAMES = {"RMC", "GSV", "GSA", "GLL", "GGA"};
	localparam int LAST_FIELD = 13;

	typedef struct packed {
		logic        kind;
		logic [3:0]  idx;
		logic [39:0] value;
		logic [2:0]  status;
		logic [2:0]  stype;
		logic [7:0]  rx_sum;
		logic [7:0]  calc_sum;
		logic        match;
	} parser_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [7:0] s_axis_tdata = 8'd0;    // [7:0] char_code
	logic s_axis_tlast = 1'b0;          // line_end
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_W-1:0] m_axis_tdata;     // [3:0] index, [43:4] value, [46:44] status,
	                                    // [49:47] type, [57:50] rx sum, [65:58] calc sum,
	                                    // [66] match
	logic m_axis_tuser;                 // kind

	int send_gap_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int lines_sent = 0;
	int chars_sent = 0;
	int fields_checked = 0;
	int summaries_checked = 0;

	parser_out_t results_due[$];
	logic [7:0] line_q[$];

	// predictor state
	logic [6:0]  line_pos;
	logic [4:0]  type_hits;
	sent_type_t  line_type;
	logic [3:0]  field_no;
	logic [39:0] digits_mag;
	logic        num_neg, num_nonempty, num_stopped;
	logic [2:0]  frac_code;    // 0 no point yet, else 1 + fraction digits kept
	logic [39:0] held_coord;
	logic [7:0]  first_char;
	logic [7:0]  xor_sum, hex_sum;
	logic        star_seen, hex_done;
	status_t     line_err;

	nmea_gga_sentence_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tlast (s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void open_number();
		digits_mag = '0;
		num_neg = 1'b0;
		num_nonempty = 1'b0;
		num_stopped = 1'b0;
		frac_code = '0;
		first_char = '0;
	endfunction

	function automatic void clear_parser();
		line_pos = '0;
		type_hits = '1;
		line_type = SENT_UNKNOWN;
		field_no = '0;
		held_coord = '0;
		xor_sum = '0;
		hex_sum = '0;
		star_seen = 1'b0;
		hex_done = 1'b0;
		line_err = ST_OK;
		open_number();
	endfunction

	function automatic logic [39:0] mul10_sat(input logic [39:0] a, input logic [3:0] d);
		logic [63:0] wide;
		wide = 64'(a);
		if (wide > (64'(MAG_MAX) - 64'(d)) / 64'd10)
			return MAG_MAX;
		return 40'(wide * 64'd10 + 64'(d));
	endfunction

	function automatic logic is_integer_field(input logic [3:0] f);
		return f == FLD_TIME || f == FLD_FIX || f == FLD_SATS || f == FLD_AGE ||
			f == FLD_STATION;
	endfunction

	function automatic logic [4:0] hex_nibble(input logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE)
			return {1'b1, 4'(c - CH_ZERO)};
		if (c >= "A" && c <= "F")
			return {1'b1, 4'(c - "A" + 8'd10)};
		if (c >= "a" && c <= "f")
			return {1'b1, 4'(c - "a" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic void take_number_char(input logic [7:0] c);
		if (!num_nonempty) begin
			num_nonempty = 1'b1;
			first_char = c;
			if (c == CH_MINUS) begin
				num_neg = 1'b1;
				return;
			end
			if (c == CH_PLUS)
				return;
		end
		if (num_stopped)
			return;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			if (frac_code == 0) begin
				digits_mag = mul10_sat(digits_mag, 4'(c - CH_ZERO));
			end else if (int'(frac_code) <= FRAC_DIGITS) begin
				digits_mag = mul10_sat(digits_mag, 4'(c - CH_ZERO));
				frac_code = frac_code + 3'd1;
			end
		end else if (c == CH_DOT && frac_code == 0 && !is_integer_field(field_no)) begin
			frac_code = 3'd1;
		end else begin
			num_stopped = 1'b1;
		end
	endfunction

	function automatic logic [39:0] scaled_value();
		logic [39:0] m;
		int kept;
		m = digits_mag;
		kept = (frac_code != 0) ? int'(frac_code) - 1 : 0;
		for (int i = kept; i < FRAC_DIGITS; i++)
			m = mul10_sat(m, 4'd0);
		return num_neg ? 40'd0 - m : m;
	endfunction

	// closes the open field, 1 when it yields a field value
	function automatic logic close_field(output logic [3:0] idx, output logic [39:0] val);
		idx = field_no;
		val = '0;
		case (field_no)
			FLD_LAT, FLD_LON: begin
				held_coord = scaled_value();
				return 1'b0;
			end
			FLD_LAT_HEMI, FLD_LON_HEMI: begin
				idx = field_no - 4'd1;
				val = (first_char == ((field_no == FLD_LAT_HEMI) ? CH_S : CH_W)) ?
					40'd0 - held_coord : held_coord;
			end
			FLD_ALT_UNITS, FLD_GEOID_UNITS: val = {32'd0, first_char};
			default: val = scaled_value();
		endcase
		return 1'b1;
	endfunction

	function automatic logic parse_char(input logic [7:0] c, input logic is_last,
			output parser_out_t r);
		logic star_before, due;
		logic [3:0] idx;
		logic [39:0] val;
		logic [4:0] h;
		logic [7:0] lead;
		int j, found;
		star_before = star_seen;
		due = 1'b0;
		idx = '0;
		val = '0;
		r = '0;

		if (int'(line_pos) >= MAX_LINE_LENGTH && line_err == ST_OK)
			line_err = ST_MALFORMED;
		lead = (line_pos == 0) ? CH_DOLLAR : (line_pos == 1) ? CH_G : CH_P;
		if (line_pos < 3 && c != lead && line_err == ST_OK)
			line_err = ST_BAD_PREFIX;
		if (line_pos >= 3 && line_pos <= 5) begin
			j = int'(line_pos) - 3;
			for (int i = 0; i < 5; i++)
				if (TYPE_NAMES[i * 24 + (2 - j) * 8 +: 8] != c)
					type_hits[i] = 1'b0;
			if (line_pos == 5 && line_err == ST_OK) begin
				found = -1;
				for (int i = 0; i < 5; i++)
					if (type_hits[i] && found < 0)
						found = i;
				if (found < 0) begin
					line_err = ST_UNKNOWN_TYPE;
				end else begin
					line_type = sent_type_t'(found + 1);
					if (line_type != SENT_GGA)
						line_err = ST_UNSUPPORTED;
				end
			end
		end

		if (!star_before) begin
			if (c == CH_STAR)
				star_seen = 1'b1;
			else if (line_pos >= 1)
				xor_sum ^= c;
		end else if (!hex_done) begin
			h = hex_nibble(c);
			if (h[4])
				hex_sum = {hex_sum[3:0], h[3:0]};
			else
				hex_done = 1'b1;
		end

		if (line_type == SENT_GGA && line_err == ST_OK) begin
			if (line_pos == 6) begin
				if (star_seen)
					line_err = ST_MALFORMED;
			end else if (line_pos >= 7) begin
				if (star_before) begin
					if (c == CH_COMMA)
						line_err = ST_MALFORMED;
				end else if (c == CH_COMMA) begin
					if (int'(field_no) >= LAST_FIELD) begin
						line_err = ST_MALFORMED;
					end else begin
						due = close_field(idx, val);
						field_no = field_no + 4'd1;
						open_number();
					end
				end else if (c == CH_STAR) begin
					if (int'(field_no) != LAST_FIELD)
						line_err = ST_MALFORMED;
					else
						due = close_field(idx, val);
				end else begin
					take_number_char(c);
				end
			end
		end

		if (line_pos < 7'd127)
			line_pos = line_pos + 7'd1;

		if (is_last) begin
			if (line_err == ST_OK) begin
				if (line_pos < 3)
					line_err = ST_BAD_PREFIX;
				else if (line_pos < 6)
					line_err = ST_UNKNOWN_TYPE;
				else if (line_type == SENT_GGA && !star_seen)
					line_err = ST_MALFORMED;
			end
			r.kind = KIND_SUMMARY;
			r.status = line_err;
			r.stype = line_type;
			r.rx_sum = hex_sum;
			r.calc_sum = star_seen ? xor_sum : 8'd0;
			r.match = (r.rx_sum == r.calc_sum);
			clear_parser();
			return 1'b1;
		end
		if (due) begin
			r.kind = KIND_FIELD;
			r.idx = idx;
			r.value = val;
			r.stype = SENT_GGA;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("tb: mismatch at %0t: %s got 'h%0h, expected 'h%0h",
			$realtime, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : result_check
		parser_out_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected result, kind", 40'(m_axis_tuser), 40'd0);
			end else begin
				want = results_due.pop_front();
				if (m_axis_tuser != want.kind)
					report_mismatch("kind", 40'(m_axis_tuser), 40'(want.kind));
				if (m_axis_tdata[3:0] != want.idx)
					report_mismatch("field_index", 40'(m_axis_tdata[3:0]), 40'(want.idx));
				if (m_axis_tdata[43:4] != want.value)
					report_mismatch("field_value", m_axis_tdata[43:4], want.value);
				if (m_axis_tdata[46:44] != want.status)
					report_mismatch("status", 40'(m_axis_tdata[46:44]), 40'(want.status));
				if (m_axis_tdata[49:47] != want.stype)
					report_mismatch("sentence_type", 40'(m_axis_tdata[49:47]),
						40'(want.stype));
				if (m_axis_tdata[57:50] != want.rx_sum)
					report_mismatch("received_checksum", 40'(m_axis_tdata[57:50]),
						40'(want.rx_sum));
				if (m_axis_tdata[65:58] != want.calc_sum)
					report_mismatch("calc_checksum", 40'(m_axis_tdata[65:58]),
						40'(want.calc_sum));
				if (m_axis_tdata[66] != want.match)
					report_mismatch("checksum_match", 40'(m_axis_tdata[66]), 40'(want.match));
				if (want.kind == KIND_SUMMARY)
					summaries_checked++;
				else
					fields_checked++;
			end
		end
	end

	task automatic send_char(input logic [7:0] c, input logic is_last);
		parser_out_t res;
		while ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= c;
		s_axis_tlast <= is_last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		chars_sent++;
		if (parse_char(c, is_last, res))
			results_due.push_back(res);
	endtask

	task automatic send_queued_line();
		for (int i = 0; i < line_q.size(); i++)
			send_char(line_q[i], i == line_q.size() - 1);
		line_q.delete();
		lines_sent++;
	endtask

	task automatic wait_quiet();
		s_axis_tvalid <= 1'b0;
		while (results_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	function automatic void add_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_q.push_back(8'(s[i]));
	endfunction

	function automatic void add_digits(input int n);
		for (int i = 0; i < n; i++)
			line_q.push_back(CH_ZERO + 8'($urandom_range(9)));
	endfunction

	// printable, but never a field or checksum separator
	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(33, 126));
		while (c == CH_COMMA || c == CH_STAR);
		return c;
	endfunction

	function automatic void add_checksum(input int style);
		logic [7:0] x;
		x = 8'd0;
		for (int i = 1; i < line_q.size(); i++) begin
			if (line_q[i] == CH_STAR)
				break;
			x ^= line_q[i];
		end
		line_q.push_back(CH_STAR);
		case (style)
			0: add_text($sformatf("%02X", x));
			1: add_text($sformatf("%02x", x));
			2: add_text($sformatf("%02X", x ^ 8'($urandom_range(1, 255))));
			3: add_text($sformatf("%1X", x[3:0]));
			4: ;
			default: begin
				add_text($sformatf("%03X", {4'($urandom_range(15)), x}));
				line_q.push_back(plain_char());
			end
		endcase
	endfunction

	function automatic int pick_sum_style();
		int r;
		r = $urandom_range(99);
		if (r < 78) return 0;
		if (r < 84) return 1;
		if (r < 90) return 2;
		if (r < 94) return 3;
		if (r < 97) return 4;
		return 5;
	endfunction

	function automatic void add_number();
		int r;
		r = $urandom_range(99);
		if (r < 12)
			return;
		r = $urandom_range(99);
		if (r < 10)
			line_q.push_back(CH_MINUS);
		else if (r < 15)
			line_q.push_back(CH_PLUS);
		if ($urandom_range(19) == 0)
			add_digits($urandom_range(8, 15));
		else
			add_digits($urandom_range(0, 4));
		if ($urandom_range(1)) begin
			line_q.push_back(CH_DOT);
			add_digits($urandom_range(0, 7));
		end
		if ($urandom_range(9) == 0) begin
			line_q.push_back(plain_char());
			add_digits($urandom_range(0, 2));
		end
	endfunction

	function automatic void add_gga_field(input logic [3:0] f);
		int r;
		r = $urandom_range(99);
		if (f == FLD_LAT_HEMI || f == FLD_LON_HEMI) begin
			if (r < 8)
				return;
			if (r < 50)
				line_q.push_back((f == FLD_LAT_HEMI) ? CH_S : CH_W);
			else if (r < 90)
				add_text((f == FLD_LAT_HEMI) ? "N" : "E");
			else begin
				line_q.push_back(plain_char());
				if ($urandom_range(1))
					line_q.push_back(plain_char());
			end
		end else if (f == FLD_ALT_UNITS || f == FLD_GEOID_UNITS) begin
			if (r < 8)
				return;
			if (r < 85)
				add_text("M");
			else
				line_q.push_back(plain_char());
		end else begin
			add_number();
		end
	endfunction

	function automatic void build_gga_line(input int style);
		add_text("$GPGGA,");
		for (int f = 0; f <= LAST_FIELD; f++) begin
			add_gga_field(4'(f));
			if (f != LAST_FIELD)
				line_q.push_back(CH_COMMA);
		end
		add_checksum(style);
	endfunction

	task automatic test_gga_fields();
		// time, both hemispheres negated, excess fraction digits, signs, units
		add_text("$GPGGA,235959,4916.45123,S,12311.1234,W,1,12,0.91234,-545.4,M,");
		add_text("+4.9,m,99.5,7");
		add_checksum(0);
		send_queued_line();
		// empty fields, saturation, negative zero, point in an integer field
		add_text("$GPGGA,,99999999999999.9,N,-0.00001,E,,,.5,,,,,,1.5");
		add_checksum(1);
		send_queued_line();
		// junk ending numbers, bare signs, leading space, negative saturation
		add_text("$GPGGA,-12a3,-99999999999,x,+7,,-,+,1e5, 12,,-99999999999999,,,");
		add_checksum(2);
		send_queued_line();
		// any character at the skipped position, zero byte inside a field
		add_text("$GPGGA#,12");
		line_q.push_back(8'h00);
		add_text("3,,,,,,,,,,,,");
		add_checksum(3);
		send_queued_line();
		wait_quiet();
	endtask

	task automatic test_line_errors();
		string other[4];
		other = '{"$GPGLL,1", "$GPGSA", "$GPGSV,,", "$GPRMC,1,2"};
		foreach (other[i]) begin
			add_text(other[i]);
			add_checksum(0);
			send_queued_line();
		end
		add_text("$");
		send_queued_line();
		add_text("$GPGG");
		send_queued_line();
		add_text("$XPGGA,,,,,,,,,,,,,*00");
		send_queued_line();
		add_text("$gpgga,1*00");
		send_queued_line();
		add_text("$GPXYZ,1*00");
		send_queued_line();
		add_text("$GPGGA*00");
		send_queued_line();
		add_text("$GPGGA,1,2");
		add_checksum(0);
		send_queued_line();
		// comma while in the station field
		add_text("$GPGGA,,,,,,,,,,,,,,");
		add_checksum(0);
		send_queued_line();
		add_text("$GPGGA,,,,,,,,,,,,,5*1,2");
		send_queued_line();
		add_text("$GPGGA,1,2,3");
		send_queued_line();
		// overlong line
		add_text("$GPGGA,");
		add_digits(90);
		add_text(",,,,,,,,,,,,,");
		add_checksum(0);
		send_queued_line();
		wait_quiet();
	endtask

	task automatic test_random_lines(input int n_chars);
		int target, r, k, n;
		string head;
		head = "$GPGGA";
		target = chars_sent + n_chars;
		while (chars_sent < target) begin
			r = $urandom_range(99);
			if (r < 58) begin
				build_gga_line(pick_sum_style());
			end else if (r < 68) begin
				k = $urandom_range(1, 4);
				add_text("$GP");
				for (int i = 2; i >= 0; i--)
					line_q.push_back(TYPE_NAMES[k * 24 + i * 8 +: 8]);
				n = $urandom_range(0, 6);
				for (int i = 0; i < n; i++) begin
					line_q.push_back(CH_COMMA);
					add_number();
				end
				add_checksum(pick_sum_style());
			end else if (r < 78) begin
				// well-formed line cut short or with a stray separator
				build_gga_line(0);
				k = $urandom_range(2);
				if (k == 0) begin
					n = $urandom_range(1, line_q.size());
					while (line_q.size() > n)
						void'(line_q.pop_back());
				end else begin
					line_q.insert($urandom_range(6, line_q.size() - 1),
						(k == 1) ? CH_COMMA : CH_STAR);
				end
			end else if (r < 86) begin
				n = $urandom_range(1, 12);
				if ($urandom_range(1))
					line_q.push_back(CH_DOLLAR);
				for (int i = 0; i < n; i++)
					line_q.push_back(8'($urandom_range(255)));
			end else if (r < 92) begin
				build_gga_line(0);
				line_q[$urandom_range(0, 5)] = 8'($urandom_range(255));
			end else if (r < 96) begin
				add_text("$GPGGA,");
				add_digits($urandom_range(76, 100));
				add_text(",,,,,,,,,,,,,");
				add_checksum(0);
			end else begin
				add_text(head.substr(0, $urandom_range(0, 4)));
			end
			send_queued_line();
		end
		wait_quiet();
	endtask

	initial begin
		clear_parser();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_gga_fields();
		test_line_errors();

		send_gap_pct = 0;
		stall_pct = 0;
		test_random_lines(250);
		send_gap_pct = 62;
		stall_pct = 0;
		test_random_lines(250);
		send_gap_pct = 0;
		stall_pct = 62;
		test_random_lines(250);
		send_gap_pct = 35;
		stall_pct = 35;
		test_random_lines(250);

		$display("tb: %0d lines in %0d characters, %0d field values and %0d summaries compared",
			lines_sent, chars_sent, fields_checked, summaries_checked);
		$display("tb: idling phases: none, sender only, receiver only, both; %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: timeout with %0d results still owed", results_due.size());
		$display("tb: FAIL");
		$finish;
	end

endmodule
